[design/hrtm_pkg.sv]
// Shared types, constants and the popcount function for the Hamming ratio-test matcher.
`timescale 1ns / 1ps

package hrtm_pkg;

    localparam int DESC_W            = 256;
    localparam int WORD_W            = 64;
    localparam int DIST_W            = 9;
    localparam int IDX_FIELD_W       = 16;
    localparam int INDEX_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 9;
    localparam int IN_DATA_W         = 272;
    localparam int OUT_DATA_W        = 40;
    localparam int CHUNKS            = DESC_W / 32;

    localparam logic [DIST_W-1:0] DIST_NONE       = 9'd256;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 9'd50;
    localparam logic [DIST_W-1:0] RATIO_RESET     = 9'd154;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 8'd1;

    localparam logic CMD_QUERY     = 1'b0;
    localparam logic CMD_CANDIDATE = 1'b1;

    localparam logic [31:0] POP_M1 = 32'h5555_5555;
    localparam logic [31:0] POP_M2 = 32'h3333_3333;
    localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;

    typedef enum logic [1:0] {
        ST_MATCH      = 2'd0,
        ST_NO_CAND    = 2'd1,
        ST_ABOVE_THR  = 2'd2,
        ST_RATIO_FAIL = 2'd3
    } status_t;

    // Per-item control flags carried from front to back
    typedef struct packed {
        logic last;
        logic taken;
        logic cmd;
    } item_ctrl_t;

    localparam int CTRL_W = $bits(item_ctrl_t);

    function automatic logic [5:0] pop32(input logic [31:0] x);
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        v1 = x - ((x >> 1) & POP_M1);
        v2 = (v1 & POP_M2) + ((v1 >> 2) & POP_M2);
        v3 = (v2 + (v2 >> 4)) & POP_M4;
        return v3[5:0] + v3[13:8] + v3[21:16] + v3[29:24];
    endfunction

endpackage

[design/hrtm_fifo.sv]
// Small register-based FIFO between the front and back parts.
`timescale 1ns / 1ps

module hrtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hrtm_pkg::QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

[design/hrtm_front.sv]
// Front part: accepts items, holds the query descriptor, computes Hamming distance in two stages.
`timescale 1ns / 1ps

module hrtm_front #(
    parameter int IDX_W = hrtm_pkg::IDX_FIELD_W,
    parameter int DEPTH = hrtm_pkg::QUEUE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [hrtm_pkg::IN_DATA_W-1:0]   in_data,
    input  logic [1:0]                       in_user,
    input  logic                             in_last,
    input  logic [CNT_W-1:0]                 q_count,
    output logic                             push,
    output hrtm_pkg::item_ctrl_t             push_ctrl,
    output logic [hrtm_pkg::DIST_W-1:0]      push_dist,
    output logic [IDX_W-1:0]                 push_idx
);

    logic                            accept;
    logic [CNT_W:0]                  occupancy;
    logic [hrtm_pkg::DESC_W-1:0]     desc;
    logic [hrtm_pkg::DESC_W-1:0]     diff;
    hrtm_pkg::item_ctrl_t            in_ctrl;

    logic [hrtm_pkg::DESC_W-1:0]     query_reg;
    logic                            a_valid_reg;
    hrtm_pkg::item_ctrl_t            a_ctrl_reg;
    logic [IDX_W-1:0]                a_idx_reg;
    logic [5:0]                      a_pop_reg [hrtm_pkg::CHUNKS];
    logic                            b_valid_reg;
    hrtm_pkg::item_ctrl_t            b_ctrl_reg;
    logic [IDX_W-1:0]                b_idx_reg;
    logic [hrtm_pkg::DIST_W-1:0]     b_dist_reg;
    logic [hrtm_pkg::DIST_W-1:0]     dist_next;

    // Credit: items in flight plus queued must leave a free slot
    assign occupancy = {1'b0, q_count} + (CNT_W + 1)'(a_valid_reg) + (CNT_W + 1)'(b_valid_reg);
    assign in_ready  = (occupancy < (CNT_W + 1)'(DEPTH));
    assign accept    = in_valid && in_ready;

    assign desc          = in_data[hrtm_pkg::DESC_W-1:0];
    assign diff          = query_reg ^ desc;
    assign in_ctrl.cmd   = in_user[0];
    assign in_ctrl.taken = in_user[1];
    assign in_ctrl.last  = in_last;

    always_comb
    begin
        dist_next = '0;
        for (int i = 0; i < hrtm_pkg::CHUNKS; i++)
        begin
            dist_next = dist_next + hrtm_pkg::DIST_W'(a_pop_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (accept && in_ctrl.cmd == hrtm_pkg::CMD_QUERY)
            begin
                query_reg <= desc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_ctrl_reg <= in_ctrl;
        a_idx_reg  <= in_data[hrtm_pkg::DESC_W +: IDX_W];
        for (int i = 0; i < hrtm_pkg::CHUNKS; i++)
        begin
            a_pop_reg[i] <= hrtm_pkg::pop32(diff[i*32 +: 32]);
        end
        b_ctrl_reg <= a_ctrl_reg;
        b_idx_reg  <= a_idx_reg;
        b_dist_reg <= dist_next;
    end

    assign push      = b_valid_reg;
    assign push_ctrl = b_ctrl_reg;
    assign push_dist = b_dist_reg;
    assign push_idx  = b_idx_reg;

endmodule

[design/hrtm_back.sv]
// Back part: best/second tracking, verdict stage and output register.
`timescale 1ns / 1ps

module hrtm_back #(
    parameter int IDX_W = hrtm_pkg::IDX_FIELD_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  hrtm_pkg::item_ctrl_t              q_ctrl,
    input  logic [hrtm_pkg::DIST_W-1:0]       q_dist,
    input  logic [IDX_W-1:0]                  q_idx,
    output logic                              q_pop,
    input  logic [hrtm_pkg::DIST_W-1:0]       match_threshold,
    input  logic [hrtm_pkg::DIST_W-1:0]       ratio_q8,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hrtm_pkg::OUT_DATA_W-1:0]   out_data
);

    localparam int DW = hrtm_pkg::DIST_W;

    logic [DW-1:0]        best_reg, best_next;
    logic [DW-1:0]        second_reg, second_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 have_reg, have_next;

    logic                 res_valid_reg;
    logic [DW-1:0]        snap_best_reg;
    logic [DW-1:0]        snap_second_reg;
    logic [IDX_W-1:0]     snap_idx_reg;
    logic                 snap_have_reg;
    logic                 res_move;

    logic                 out_valid_reg;
    logic                 out_matched_reg;
    logic [hrtm_pkg::IDX_FIELD_W-1:0] out_idx_reg;
    logic [DW-1:0]        out_best_reg;
    logic [DW-1:0]        out_second_reg;
    hrtm_pkg::status_t    out_status_reg;

    hrtm_pkg::status_t    status;
    logic [2*DW-1:0]      ratio_prod;
    logic [2*DW-1:0]      best_scaled;

    always_comb
    begin
        best_next   = best_reg;
        second_next = second_reg;
        idx_next    = idx_reg;
        have_next   = have_reg;
        if (q_ctrl.cmd == hrtm_pkg::CMD_QUERY)
        begin
            best_next   = hrtm_pkg::DIST_NONE;
            second_next = hrtm_pkg::DIST_NONE;
            idx_next    = '0;
            have_next   = 1'b0;
        end
        else if (!q_ctrl.taken)
        begin
            // Ties keep the earlier best
            if (q_dist < best_reg)
            begin
                second_next = best_reg;
                best_next   = q_dist;
                idx_next    = q_idx;
                have_next   = 1'b1;
            end
            else if (q_dist < second_reg)
            begin
                second_next = q_dist;
            end
        end
    end

    assign res_move = res_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop    = q_valid && (!q_ctrl.last || !res_valid_reg || res_move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= hrtm_pkg::DIST_NONE;
            second_reg    <= hrtm_pkg::DIST_NONE;
            idx_reg       <= '0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_ctrl.last)
                begin
                    best_reg   <= hrtm_pkg::DIST_NONE;
                    second_reg <= hrtm_pkg::DIST_NONE;
                    idx_reg    <= '0;
                    have_reg   <= 1'b0;
                end
                else
                begin
                    best_reg   <= best_next;
                    second_reg <= second_next;
                    idx_reg    <= idx_next;
                    have_reg   <= have_next;
                end
            end
            if (q_pop && q_ctrl.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_ctrl.last)
        begin
            snap_best_reg   <= best_next;
            snap_second_reg <= second_next;
            snap_idx_reg    <= idx_next;
            snap_have_reg   <= have_next;
        end
    end

    assign ratio_prod  = (2*DW)'(ratio_q8) * (2*DW)'(snap_second_reg);
    assign best_scaled = {1'b0, snap_best_reg, 8'h00};

    always_comb
    begin
        if (!snap_have_reg)
        begin
            status = hrtm_pkg::ST_NO_CAND;
        end
        else if (snap_best_reg > match_threshold)
        begin
            status = hrtm_pkg::ST_ABOVE_THR;
        end
        else if (!(best_scaled < ratio_prod))
        begin
            status = hrtm_pkg::ST_RATIO_FAIL;
        end
        else
        begin
            status = hrtm_pkg::ST_MATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_move)
        begin
            out_matched_reg <= (status == hrtm_pkg::ST_MATCH);
            out_idx_reg     <= snap_have_reg ? hrtm_pkg::IDX_FIELD_W'(snap_idx_reg) : '0;
            out_best_reg    <= snap_best_reg;
            out_second_reg  <= snap_second_reg;
            out_status_reg  <= status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {3'b000, out_status_reg, out_second_reg, out_best_reg,
                        out_idx_reg, out_matched_reg};

endmodule

[design/hamming_ratio_test_matcher.sv]
// Top level of the Hamming-distance nearest-neighbor matcher with ratio test.
// Throughput: one item per cycle, queries and candidates alike, while the front has credit.
// m_axis_tvalid rises once the item marked last has passed, after its transfer,
//   the second distance stage, the queue, the tracker and the verdict stage.
// The front stalls only when its credit against the 4-entry queue runs out.
// Reset (rst_n, async, active low): query cleared, search cleared, registers 50 / 154.
`timescale 1ns / 1ps

module hamming_ratio_test_matcher #(
    parameter int INDEX_BITS = hrtm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // desc_word0, desc_word1, desc_word2, desc_word3, cand_index
    input  logic [hrtm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd, cand_taken
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // matched, best_index, best_distance, second_distance, status, zero pad
    output logic [hrtm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hrtm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hrtm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W  = (INDEX_BITS < hrtm_pkg::IDX_FIELD_W) ? INDEX_BITS
                                                                 : hrtm_pkg::IDX_FIELD_W;
    localparam int DEPTH  = hrtm_pkg::QUEUE_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ITEM_W = hrtm_pkg::CTRL_W + hrtm_pkg::DIST_W + IDX_W;

    logic [hrtm_pkg::DIST_W-1:0] threshold_reg;
    logic [hrtm_pkg::DIST_W-1:0] ratio_reg;

    logic                          push;
    hrtm_pkg::item_ctrl_t          push_ctrl;
    logic [hrtm_pkg::DIST_W-1:0]   push_dist;
    logic [IDX_W-1:0]              push_idx;
    logic [ITEM_W-1:0]             q_wdata;
    logic [ITEM_W-1:0]             q_rdata;
    logic                          q_valid;
    logic                          q_pop;
    logic [CNT_W-1:0]              q_count;
    hrtm_pkg::item_ctrl_t          q_ctrl;
    logic [hrtm_pkg::DIST_W-1:0]   q_dist;
    logic [IDX_W-1:0]              q_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= hrtm_pkg::THRESHOLD_RESET;
            ratio_reg     <= hrtm_pkg::RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hrtm_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                hrtm_pkg::REG_RATIO:     ratio_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    hrtm_front #(
        .IDX_W (IDX_W),
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .q_count   (q_count),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_dist (push_dist),
        .push_idx  (push_idx)
    );

    assign q_wdata = {push_idx, push_dist, push_ctrl};

    hrtm_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (q_wdata),
        .rd_en     (q_pop),
        .rd_data   (q_rdata),
        .not_empty (q_valid),
        .count     (q_count)
    );

    assign q_ctrl = q_rdata[hrtm_pkg::CTRL_W-1:0];
    assign q_dist = q_rdata[hrtm_pkg::CTRL_W +: hrtm_pkg::DIST_W];
    assign q_idx  = q_rdata[hrtm_pkg::CTRL_W + hrtm_pkg::DIST_W +: IDX_W];

    hrtm_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ctrl          (q_ctrl),
        .q_dist          (q_dist),
        .q_idx           (q_idx),
        .q_pop           (q_pop),
        .match_threshold (threshold_reg),
        .ratio_q8        (ratio_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata)
    );

    // Credit scheme must never overrun the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < CNT_W'(DEPTH)) || q_pop)
        else $error("queue overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[36:35] == hrtm_pkg::ST_MATCH)))
        else $error("matched flag disagrees with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:17] <= m_axis_tdata[34:26]))
        else $error("best distance above second distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[36:35] == hrtm_pkg::ST_NO_CAND)
        |-> (m_axis_tdata[16:1] == '0 && m_axis_tdata[25:17] == hrtm_pkg::DIST_NONE))
        else $error("no-candidate result carries a best");

endmodule

[sim/tb.sv]
// Self-checking testbench for the Hamming ratio-test matcher.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 235;
    localparam logic [hrtm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

    typedef struct {
        logic         cmd;
        logic [255:0] desc;
        logic [15:0]  idx;
        logic         taken;
        logic         last;
    } match_item_t;

    typedef struct {
        logic              matched;
        logic [15:0]       best_index;
        logic [8:0]        best_distance;
        logic [8:0]        second_distance;
        hrtm_pkg::status_t status;
    } match_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [hrtm_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [hrtm_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [hrtm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [hrtm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    match_item_t   pending_items[$];
    match_result_t expected_matches[$];

    // predictor state
    logic [255:0] query_reg;
    int           trk_best;
    int           trk_second;
    logic [15:0]  trk_idx;
    logic         trk_have;
    int           thr_reg;
    int           ratio_reg;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    // stimulus generator view of the loaded query
    logic [255:0] gen_query;
    logic [255:0] last_mask;

    hamming_ratio_test_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void clear_search();
        trk_best   = 256;
        trk_second = 256;
        trk_idx    = '0;
        trk_have   = 1'b0;
    endfunction

    function automatic void predict_match(input match_item_t it);
        int            d;
        match_result_t r;
        if (it.cmd == hrtm_pkg::CMD_QUERY)
        begin
            query_reg = it.desc;
            clear_search();
        end
        else if (!it.taken)
        begin
            d = $countones(query_reg ^ it.desc);
            if (d < trk_best)
            begin
                trk_second = trk_best;
                trk_best   = d;
                trk_idx    = it.idx;
                trk_have   = 1'b1;
            end
            else if (d < trk_second)
            begin
                trk_second = d;
            end
        end
        if (it.last)
        begin
            if (!trk_have)
                r.status = hrtm_pkg::ST_NO_CAND;
            else if (trk_best > thr_reg)
                r.status = hrtm_pkg::ST_ABOVE_THR;
            else if (!(trk_best * 256 < ratio_reg * trk_second))
                r.status = hrtm_pkg::ST_RATIO_FAIL;
            else
                r.status = hrtm_pkg::ST_MATCH;
            r.matched         = (r.status == hrtm_pkg::ST_MATCH);
            r.best_index      = trk_have ? trk_idx : 16'd0;
            r.best_distance   = trk_best[8:0];
            r.second_distance = trk_second[8:0];
            expected_matches.insert(expected_matches.size(), r);
            clear_search();
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic        show;
        match_item_t nxt;
        if (rst_n)
        begin
            show = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_match(pending_items.pop_front());
                show = 1'b0;
            end
            if (!show && pending_items.size() != 0
                && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = pending_items[0];
                s_axis_tdata <= {nxt.idx, nxt.desc};
                s_axis_tuser <= {nxt.taken, nxt.cmd};
                s_axis_tlast <= nxt.last;
                show = 1'b1;
            end
            s_axis_tvalid <= show;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        match_result_t e;
        logic          bad;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_matches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %h", m_axis_tdata);
                end
                else
                begin
                    e = expected_matches.pop_front();
                    bad = (m_axis_tdata[0] !== e.matched)
                        || (m_axis_tdata[16:1] !== e.best_index)
                        || (m_axis_tdata[25:17] !== e.best_distance)
                        || (m_axis_tdata[34:26] !== e.second_distance)
                        || (m_axis_tdata[36:35] !== e.status);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: exp m=%0d idx=%0d best=%0d second=%0d st=%0d,",
                                e.matched, e.best_index, e.best_distance,
                                e.second_distance, e.status);
                            $display(" got m=%0d idx=%0d best=%0d second=%0d st=%0d",
                                m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[25:17],
                                m_axis_tdata[34:26], m_axis_tdata[36:35]);
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    function automatic logic [255:0] rand_desc();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    function automatic logic [255:0] low_bits(input int k);
        return (k >= 256) ? '1 : ((256'd1 << k) - 256'd1);
    endfunction

    // flip pattern whose density sets the distance to the query
    function automatic logic [255:0] flip_mask();
        logic [255:0] m;
        int           sel;
        sel = $urandom_range(15);
        case (sel)
            0: m = '0;
            1: m = '1;
            2: m = ~(rand_desc() & rand_desc() & rand_desc() & rand_desc());
            default:
            begin
                m = rand_desc();
                for (int i = $urandom_range(7); i > 0; i--)
                    m &= rand_desc();
            end
        endcase
        return m;
    endfunction

    function automatic void add_item(input logic cmd, input logic [255:0] desc,
                                     input logic [15:0] idx, input logic taken,
                                     input logic last);
        match_item_t it;
        it.cmd   = cmd;
        it.desc  = desc;
        it.idx   = idx;
        it.taken = taken;
        it.last  = last;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void add_candidate(input logic last);
        logic [255:0] m;
        if ($urandom_range(99) < 15)
            m = last_mask;
        else
            m = flip_mask();
        last_mask = m;
        add_item(hrtm_pkg::CMD_CANDIDATE, gen_query ^ m, 16'($urandom),
                 $urandom_range(99) < 15, last);
    endfunction

    // adds one query/candidate run or some noise to the phase; returns the item count
    function automatic int add_random_run();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 78)
        begin
            gen_query = rand_desc();
            add_item(hrtm_pkg::CMD_QUERY, gen_query, 16'($urandom),
                     1'($urandom_range(1)), 1'b0);
            n = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                add_candidate(i == n - 1);
            return n + 1;
        end
        else if (r < 86)
        begin
            gen_query = rand_desc();
            add_item(hrtm_pkg::CMD_QUERY, gen_query, 16'($urandom),
                     1'($urandom_range(1)), 1'b1);
            return 1;
        end
        else if (r < 94)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_candidate(i == n - 1);
            return n;
        end
        else
        begin
            add_item(1'($urandom_range(1)), rand_desc(), 16'($urandom),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
            if (pending_items[$].cmd == hrtm_pkg::CMD_QUERY)
                gen_query = pending_items[$].desc;
            return 1;
        end
    endfunction

    task automatic write_reg(input logic [hrtm_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[hrtm_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == hrtm_pkg::REG_THRESHOLD)
            thr_reg = val & 511;
        else if (idx == hrtm_pkg::REG_RATIO)
            ratio_reg = val & 511;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int           thr_set[8];
        int           ratio_set[8];
        int           count;
        logic [255:0] q;
        thr_set   = '{256, 0, 80, 511, 30, 256, 0, 50};
        ratio_set = '{256, 0, 200, 511, 100, 0, 256, 154};
        query_reg = '0;
        thr_reg   = hrtm_pkg::THRESHOLD_RESET;
        ratio_reg = hrtm_pkg::RATIO_RESET;
        clear_search();
        gen_query = '0;
        last_mask = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero query after reset, ties, all-256 runs, threshold and ratio edges
        add_item(hrtm_pkg::CMD_CANDIDATE, '0, 16'h0000, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_QUERY, '1, 16'h0000, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, '1, 16'hFFFF, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, '0, 16'd5, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, '1, 16'd1, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, '1, 16'd7, 1'b1, 1'b1);
        add_item(hrtm_pkg::CMD_QUERY, '0, 16'd0, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, '1, 16'd3, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(60), 16'd9, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(50), 16'd10, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(10), 16'd11, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(20), 16'd12, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(15), 16'd13, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(10), 16'd14, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, '0, 16'd15, 1'b1, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(51), 16'd16, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 16'h8000,
                 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, {4{64'h5555_5555_5555_5555}}, 16'h7FFF,
                 1'b0, 1'b1);
        q = rand_desc();
        add_item(hrtm_pkg::CMD_QUERY, q, 16'd0, 1'b1, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, q, 16'hFFFF, 1'b0, 1'b1);
        add_item(hrtm_pkg::CMD_CANDIDATE, q ^ low_bits(5), 16'd21, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_QUERY, '0, 16'd0, 1'b0, 1'b0);
        add_item(hrtm_pkg::CMD_CANDIDATE, low_bits(3), 16'd23, 1'b0, 1'b1);
        gen_query = '0;
        drain();

        write_reg(REG_UNUSED, 511);
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 46;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 46;
                end
                default:
                begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 10;
                end
            endcase
            if (ph == 7)
            begin
                write_reg(hrtm_pkg::REG_THRESHOLD, $urandom_range(511));
                write_reg(hrtm_pkg::REG_RATIO, $urandom_range(511));
            end
            else
            begin
                write_reg(hrtm_pkg::REG_THRESHOLD, thr_set[ph]);
                write_reg(hrtm_pkg::REG_RATIO, ratio_set[ph]);
            end
            count = 0;
            while (count < PHASE_ITEMS)
                count += add_random_run();
            drain();
        end

        if (mismatches == 0 && expected_matches.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
